// ===== rtl/core/tlsf_pkg.sv =====
`default_nettype none

package tlsf_pkg;

    // slot store geometry
    localparam int MAX_SLOTS  = 256;
    localparam int SLOT_AW    = $clog2(MAX_SLOTS);
    localparam int BANK_DEPTH = MAX_SLOTS / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // field widths
    localparam int CFG_W   = 9;
    localparam int LIM_W   = SLOT_AW + 1;
    localparam int IDX_W   = 16;
    localparam int TAG_W   = 3;
    localparam int WORD_W  = 32;
    localparam int VALUE_W = 2 * WORD_W;

    // reset value of the slot count register
    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(256);

    // slot type tags
    localparam logic [TAG_W-1:0] TAG_EMPTY  = 3'd0;
    localparam logic [TAG_W-1:0] TAG_OBJECT = 3'd1;
    localparam logic [TAG_W-1:0] TAG_INT    = 3'd2;
    localparam logic [TAG_W-1:0] TAG_FLOAT  = 3'd3;
    localparam logic [TAG_W-1:0] TAG_LONG   = 3'd4;
    localparam logic [TAG_W-1:0] TAG_DOUBLE = 3'd5;

    // request kinds
    typedef enum logic [1:0] {
        REQ_WR_ONE  = 2'd0,
        REQ_WR_PAIR = 2'd1,
        REQ_RD_ONE  = 2'd2,
        REQ_RD_PAIR = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_BAD_TAG   = 2'd3
    } t_status;

    // one slot entry as stored in a bank
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [WORD_W-1:0] word;
    } t_slot;

endpackage

`default_nettype wire

// ===== rtl/core/tlsf_bank.sv =====
`default_nettype none

// one bank of slots: tag and word per entry, one write and one read port,
// registered read; tags of never-written entries read as empty
module tlsf_bank (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_we,
    input  wire  [tlsf_pkg::BANK_AW-1:0]   i_waddr,
    input  wire  tlsf_pkg::t_slot          i_wdata,
    input  wire                            i_re,
    input  wire  [tlsf_pkg::BANK_AW-1:0]   i_raddr,
    output tlsf_pkg::t_slot                o_rdata
);

    tlsf_pkg::t_slot                    r_mem [tlsf_pkg::BANK_DEPTH];
    logic [tlsf_pkg::BANK_DEPTH-1:0]    r_valid;
    tlsf_pkg::t_slot                    r_rd;
    logic                               r_rd_valid;

    // entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // storage array and read register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd       <= r_mem[i_raddr];
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    // unwritten entries show the empty tag
    always_comb begin
        o_rdata      = r_rd;
        o_rdata.tag  = r_rd_valid ? r_rd.tag : tlsf_pkg::TAG_EMPTY;
    end

endmodule

`default_nettype wire

// ===== rtl/core/typed_local_slot_file_top.sv =====
`default_nettype none

// result path: input beat, then bank read register, then result register
// throughput: one item per cycle while the result side is not stalled; even and odd slots
// sit in separate banks so a pair is one access to each bank
// reset: synchronous active-low; slot tags read empty, slot count returns to 256,
// no item in flight
module typed_local_slot_file_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [tlsf_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire  [79:0]                      i_s_axis_tdata,  // slot_index, write_value
    input  wire  [4:0]                       i_s_axis_tuser,  // req_type, type_tag
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic [63:0]                      o_m_axis_tdata,  // read_value
    output logic [1:0]                       o_m_axis_tuser   // status
);

    // input fields
    tlsf_pkg::t_req                       w_req;
    logic [tlsf_pkg::TAG_W-1:0]           w_tag;
    logic [tlsf_pkg::IDX_W-1:0]           w_idx;
    logic [tlsf_pkg::VALUE_W-1:0]         w_wval;
    logic [tlsf_pkg::WORD_W-1:0]          w_wlo;
    logic [tlsf_pkg::WORD_W-1:0]          w_whi;

    assign w_req  = tlsf_pkg::t_req'(i_s_axis_tuser[1:0]);
    assign w_tag  = i_s_axis_tuser[4:2];
    assign w_idx  = i_s_axis_tdata[15:0];
    assign w_wval = i_s_axis_tdata[79:16];
    assign w_wlo  = w_wval[tlsf_pkg::WORD_W-1:0];
    assign w_whi  = w_wval[tlsf_pkg::VALUE_W-1:tlsf_pkg::WORD_W];

    // slot count register
    logic [tlsf_pkg::CFG_W-1:0]           r_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= tlsf_pkg::SLOTS_RESET;
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_wdata;
        end
    end

    // handshake control, no input beat taken during reset
    logic                                 r_s1_valid;
    logic                                 w_advance;
    logic                                 w_accept;

    assign w_advance       = r_s1_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || w_advance);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // limit, tag and index checks
    logic [tlsf_pkg::LIM_W-1:0]           w_lim;
    logic [tlsf_pkg::IDX_W:0]             w_idx_last;
    logic                                 w_pair;
    logic                                 w_tag_ok;
    logic                                 w_idx_ok;
    tlsf_pkg::t_status                    w_pre_status;

    assign w_lim = (32'(r_slots) > tlsf_pkg::MAX_SLOTS) ?
                   tlsf_pkg::LIM_W'(tlsf_pkg::MAX_SLOTS) :
                   tlsf_pkg::LIM_W'(r_slots);
    assign w_pair     = (w_req == tlsf_pkg::REQ_WR_PAIR) || (w_req == tlsf_pkg::REQ_RD_PAIR);
    assign w_idx_last = {1'b0, w_idx} + (w_pair ? 17'd1 : 17'd0);
    assign w_idx_ok   = w_idx_last < (tlsf_pkg::IDX_W+1)'(w_lim);
    assign w_tag_ok   = w_pair ?
                        ((w_tag == tlsf_pkg::TAG_LONG) || (w_tag == tlsf_pkg::TAG_DOUBLE)) :
                        ((w_tag == tlsf_pkg::TAG_OBJECT) || (w_tag == tlsf_pkg::TAG_INT) ||
                         (w_tag == tlsf_pkg::TAG_FLOAT));

    always_comb begin
        if (!w_tag_ok) begin
            w_pre_status = tlsf_pkg::ST_BAD_TAG;
        end else if (!w_idx_ok) begin
            w_pre_status = tlsf_pkg::ST_BAD_INDEX;
        end else begin
            w_pre_status = tlsf_pkg::ST_OK;
        end
    end

    // bank addressing: even slots in bank e, odd slots in bank o
    logic                                 w_odd;
    logic [tlsf_pkg::BANK_AW-1:0]         w_a_lo;
    logic [tlsf_pkg::BANK_AW-1:0]         w_a_hi;
    logic                                 w_do_write;
    logic                                 w_e_we;
    logic                                 w_o_we;
    logic [tlsf_pkg::BANK_AW-1:0]         w_e_addr;
    tlsf_pkg::t_slot                      w_first_wr;
    tlsf_pkg::t_slot                      w_second_wr;
    tlsf_pkg::t_slot                      w_e_wdata;
    tlsf_pkg::t_slot                      w_o_wdata;
    tlsf_pkg::t_slot                      w_e_rd;
    tlsf_pkg::t_slot                      w_o_rd;

    assign w_odd      = w_idx[0];
    assign w_a_lo     = w_idx[tlsf_pkg::SLOT_AW-1:1];
    assign w_a_hi     = w_a_lo + tlsf_pkg::BANK_AW'(1);
    assign w_do_write = w_accept && (w_pre_status == tlsf_pkg::ST_OK) &&
                        ((w_req == tlsf_pkg::REQ_WR_ONE) || (w_req == tlsf_pkg::REQ_WR_PAIR));
    assign w_e_we     = w_do_write && (w_pair || !w_odd);
    assign w_o_we     = w_do_write && (w_pair || w_odd);
    assign w_e_addr   = w_odd ? w_a_hi : w_a_lo;

    assign w_first_wr  = '{tag: w_tag, word: w_wlo};
    assign w_second_wr = '{tag: tlsf_pkg::TAG_EMPTY, word: w_whi};
    assign w_e_wdata   = (w_pair && w_odd) ? w_second_wr : w_first_wr;
    assign w_o_wdata   = (w_pair && !w_odd) ? w_second_wr : w_first_wr;

    tlsf_bank u_bank_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_e_we),
        .i_waddr (w_e_addr),
        .i_wdata (w_e_wdata),
        .i_re    (w_accept),
        .i_raddr (w_e_addr),
        .o_rdata (w_e_rd)
    );

    tlsf_bank u_bank_o (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_o_we),
        .i_waddr (w_a_lo),
        .i_wdata (w_o_wdata),
        .i_re    (w_accept),
        .i_raddr (w_a_lo),
        .o_rdata (w_o_rd)
    );

    // stage 1: request held while bank data comes back
    tlsf_pkg::t_req                       r_s1_req;
    logic [tlsf_pkg::TAG_W-1:0]           r_s1_tag;
    logic                                 r_s1_odd;
    tlsf_pkg::t_status                    r_s1_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req    <= w_req;
            r_s1_tag    <= w_tag;
            r_s1_odd    <= w_odd;
            r_s1_status <= w_pre_status;
        end
    end

    // tag check and result assembly
    tlsf_pkg::t_slot                      w_first_rd;
    tlsf_pkg::t_slot                      w_second_rd;
    tlsf_pkg::t_status                    n_status;
    logic [tlsf_pkg::VALUE_W-1:0]         n_value;

    assign w_first_rd  = r_s1_odd ? w_o_rd : w_e_rd;
    assign w_second_rd = r_s1_odd ? w_e_rd : w_o_rd;

    always_comb begin
        n_status = r_s1_status;
        n_value  = '0;
        if (r_s1_status == tlsf_pkg::ST_OK) begin
            case (r_s1_req)
                tlsf_pkg::REQ_RD_ONE: begin
                    if (w_first_rd.tag != r_s1_tag) begin
                        n_status = tlsf_pkg::ST_MISMATCH;
                    end else begin
                        n_value = {{tlsf_pkg::WORD_W{1'b0}}, w_first_rd.word};
                    end
                end
                tlsf_pkg::REQ_RD_PAIR: begin
                    if ((w_first_rd.tag != r_s1_tag) ||
                        (w_second_rd.tag != tlsf_pkg::TAG_EMPTY)) begin
                        n_status = tlsf_pkg::ST_MISMATCH;
                    end else begin
                        n_value = {w_second_rd.word, w_first_rd.word};
                    end
                end
                default: begin
                    n_value = '0;
                end
            endcase
        end
    end

    // output register
    logic                                 r_out_valid;
    logic [tlsf_pkg::VALUE_W-1:0]         r_out_value;
    tlsf_pkg::t_status                    r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_value  <= n_value;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/core/tlsf_checker.sv =====
`default_nettype none

module tlsf_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [tlsf_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire                              i_s_axis_tvalid,
    input  wire                              o_s_axis_tready,
    input  wire  [79:0]                      i_s_axis_tdata,
    input  wire  [4:0]                       i_s_axis_tuser,
    input  wire                              o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    input  wire  [63:0]                      o_m_axis_tdata,
    input  wire  [1:0]                       o_m_axis_tuser
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result payload changed while stalled");

    // any error status carries a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != tlsf_pkg::ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("nonzero value on error result");

endmodule

bind typed_local_slot_file_top tlsf_checker u_tlsf_checker (.*);

`default_nettype wire
